// File: rtl/adf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_pkg: shared types and constants of the converter link deframer
// Frame geometry, header masks, result codes and the result word layout.
// ----------------------------------------------------------------------------
package adf_pkg;

	localparam int CHANNELS = 16;
	localparam int SIDX_W   = $clog2(CHANNELS);
	localparam int CNT_W    = $clog2(CHANNELS + 1);

	localparam logic [7:0] CLOSE_RESET = 8'h73;
	localparam logic [7:0] HDR1_MASK   = 8'hC0;
	localparam logic [7:0] HDR2_MASK   = 8'hCF;
	localparam logic [7:0] HDR_VALUE   = 8'h80;

	typedef logic [2:0]  code_t;
	typedef logic [3:0]  channel_t;
	typedef logic [14:0] sample_t;
	typedef logic [5:0]  frame_t;

	localparam code_t ERR_SAMPLE   = 3'd0;
	localparam code_t ERR_SKIP     = 3'd1;
	localparam code_t ERR_HEADER   = 3'd2;
	localparam code_t ERR_HIGH     = 3'd3;
	localparam code_t ERR_CLOSE    = 3'd4;
	localparam code_t ERR_OVERFLOW = 3'd5;

	typedef struct packed {
		code_t    code;
		channel_t channel;
		sample_t  value;
		frame_t   frame;
		frame_t   skipped;
		logic     first;
		logic     last;
	} res_t;

	typedef struct packed {
		logic    single;
		logic    burst;
		code_t   code;
		frame_t  skipped;
		frame_t  frame;
		logic    first;
		logic    shift;
		sample_t sample;
	} evt_t;

endpackage

// File: rtl/adf_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_parser: frame parser of the converter link deframer
// Tracks the frame phase, checks headers and counter continuity, and reports
// per byte whether it shifts a sample, emits one error word or a whole frame.
// ----------------------------------------------------------------------------
module adf_parser (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  logic [7:0]    link_byte,
	input  logic          sink_full,
	input  logic [7:0]    close_marker,
	output adf_pkg::evt_t evt
);
	import adf_pkg::*;

	typedef enum logic [2:0] {
		PH_SEARCH = 3'd0,
		PH_HEAD   = 3'd1,
		PH_HIGH   = 3'd2,
		PH_LOW    = 3'd3,
		PH_CLOSE  = 3'd4
	} phase_t;

	phase_t            ph_q, ph_d;
	frame_t            cur_q, cur_d, prev_q, prev_d;
	logic              pv_q, pv_d, fp_q, fp_d, ff_q, ff_d;
	logic [SIDX_W-1:0] idx_q, idx_d;
	logic [6:0]        hi_q, hi_d;
	frame_t            gap;
	logic              hdr1, hdr2, restart, reparse;

	assign hdr1 = (link_byte & HDR1_MASK) == HDR_VALUE;
	assign hdr2 = (link_byte & HDR2_MASK) == HDR_VALUE;
	assign gap  = cur_q - prev_q;

	always_comb begin
		ph_d        = ph_q;
		cur_d       = cur_q;
		prev_d      = prev_q;
		pv_d        = pv_q;
		fp_d        = fp_q;
		ff_d        = ff_q;
		idx_d       = idx_q;
		hi_d        = hi_q;
		restart     = 1'b0;
		reparse     = 1'b0;
		evt         = '0;
		evt.frame   = cur_q;
		evt.first   = ff_q;
		evt.sample  = {hi_q, link_byte};
		unique case (ph_q)
			PH_HEAD: begin
				if (hdr2) begin
					if (pv_q && (gap >= 6'd2)) begin
						evt.single  = 1'b1;
						evt.code    = ERR_SKIP;
						evt.skipped = gap - 6'd1;
						restart     = 1'b1;
						reparse     = 1'b1;
					end else begin
						ff_d  = fp_q;
						fp_d  = 1'b0;
						idx_d = '0;
						ph_d  = PH_HIGH;
					end
				end else if (!pv_q) begin
					reparse = 1'b1;
				end else begin
					evt.single = 1'b1;
					evt.code   = ERR_HEADER;
					restart    = 1'b1;
					reparse    = 1'b1;
				end
			end
			PH_HIGH: begin
				if (link_byte[7]) begin
					evt.single = 1'b1;
					evt.code   = ERR_HIGH;
					restart    = 1'b1;
					reparse    = 1'b1;
				end else begin
					hi_d = link_byte[6:0];
					ph_d = PH_LOW;
				end
			end
			PH_LOW: begin
				evt.shift = 1'b1;
				idx_d     = idx_q + SIDX_W'(1);
				if (idx_q == SIDX_W'(CHANNELS - 1)) begin
					prev_d = cur_q;
					pv_d   = 1'b1;
					ph_d   = PH_CLOSE;
				end else begin
					ph_d = PH_HIGH;
				end
			end
			PH_CLOSE: begin
				if (link_byte != close_marker) begin
					evt.single = 1'b1;
					evt.code   = ERR_CLOSE;
					restart    = 1'b1;
					reparse    = 1'b1;
				end else begin
					ph_d = PH_SEARCH;
					if (sink_full) begin
						evt.single = 1'b1;
						evt.code   = ERR_OVERFLOW;
						fp_d       = 1'b1;
					end else begin
						evt.burst = 1'b1;
					end
				end
			end
			default: begin
				reparse = 1'b1;
			end
		endcase
		if (restart) begin
			pv_d = 1'b0;
			fp_d = 1'b1;
		end
		if (reparse) begin
			ph_d = PH_SEARCH;
			if (hdr1) begin
				ph_d  = PH_HEAD;
				cur_d = link_byte[5:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q   <= PH_SEARCH;
			cur_q  <= '0;
			prev_q <= '0;
			pv_q   <= 1'b0;
			fp_q   <= 1'b1;
			ff_q   <= 1'b0;
			idx_q  <= '0;
			hi_q   <= '0;
		end else if (fire) begin
			ph_q   <= ph_d;
			cur_q  <= cur_d;
			prev_q <= prev_d;
			pv_q   <= pv_d;
			fp_q   <= fp_d;
			ff_q   <= ff_d;
			idx_q  <= idx_d;
			hi_q   <= hi_d;
		end
	end

endmodule

// File: rtl/adf_cap_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_cap_cell: one cell of the sample capture chain
// Holds one received sample and takes its neighbor's on every sample shift.
// ----------------------------------------------------------------------------
module adf_cap_cell (
	input  logic             clk,
	input  logic             shift,
	input  adf_pkg::sample_t d,
	output adf_pkg::sample_t q
);
	import adf_pkg::*;

	sample_t data_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			data_q <= d;
		end
	end

	assign q = data_q;

endmodule

// File: rtl/adf_out_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adf_out_cell: one cell of the result chain
// Loads a result word in parallel or advances the neighbor's word on a pop.
// ----------------------------------------------------------------------------
module adf_out_cell (
	input  logic           clk,
	input  logic           load,
	input  adf_pkg::res_t  load_item,
	input  logic           shift,
	input  adf_pkg::res_t  next_item,
	output adf_pkg::res_t  item
);
	import adf_pkg::*;

	res_t item_q;

	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= load_item;
		end else if (shift) begin
			item_q <= next_item;
		end
	end

	assign item = item_q;

endmodule

// File: rtl/adc_frame_deframer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_deframer_core: byte-serial frame deframer for a converter link
// Parses header, sample and closing bytes and emits rotated frame samples or
// error words through a chain of result cells.
// ----------------------------------------------------------------------------
// The block accepts one link byte per clock. Bytes that yield no result
// (search, header and sample bytes of a good frame) are always taken; a byte
// that yields results (an error, an overflow or a good close) is taken only
// once the result chain is empty. The chain of CHANNELS cells drains one
// word per cycle toward the output while m_tready is high; a good close loads
// CHANNELS words, fewer than the 2*CHANNELS+3 bytes of a frame. The closing
// marker register may be written at any time the block is idle.
module adc_frame_deframer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,    // close_marker
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // link_byte
	input  logic [0:0]  s_tuser,     // sink_full
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // channel, sample_value, frame_number,
	                                 // skipped_count, zero pad
	output logic [3:0]  m_tuser,     // error_code, first_of_stream
	output logic        m_tlast      // last
);
	import adf_pkg::*;

	logic [7:0]       close_q;
	evt_t             evt;
	logic             s_fire, pop, emit;
	logic [CNT_W-1:0] cnt_q;
	sample_t          cap    [CHANNELS];
	res_t             out_item [CHANNELS];
	res_t             single_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			close_q <= CLOSE_RESET;
		end else if (cfg_valid) begin
			close_q <= cfg_data;
		end
	end

	adf_parser u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (s_fire),
		.link_byte    (s_tdata),
		.sink_full    (s_tuser[0]),
		.close_marker (close_q),
		.evt          (evt)
	);

	assign emit     = evt.single || evt.burst;
	assign s_tready = (cnt_q == '0) || !emit;
	assign s_fire   = s_tvalid && s_tready;
	assign m_tvalid = cnt_q != '0;
	assign pop      = m_tvalid && m_tready;

	always_comb begin
		single_item         = '0;
		single_item.code    = evt.code;
		single_item.frame   = evt.frame;
		single_item.skipped = evt.skipped;
		single_item.last    = 1'b1;
	end

	for (genvar j = 0; j < CHANNELS; j++) begin : g_cap
		sample_t d;
		if (j == 0) begin : g_head
			assign d = evt.sample;
		end else begin : g_body
			assign d = cap[j-1];
		end
		adf_cap_cell u_cell (
			.clk   (clk),
			.shift (s_fire && evt.shift),
			.d     (d),
			.q     (cap[j])
		);
	end

	for (genvar k = 0; k < CHANNELS; k++) begin : g_out
		localparam int SRC = (k == CHANNELS - 1) ? CHANNELS - 1 : CHANNELS - 2 - k;
		res_t burst_item, load_item, next_item;
		logic load;
		always_comb begin
			burst_item         = '0;
			burst_item.code    = ERR_SAMPLE;
			burst_item.channel = channel_t'(k);
			burst_item.value   = cap[SRC];
			burst_item.frame   = evt.frame;
			burst_item.first   = evt.first;
			burst_item.last    = (k == CHANNELS - 1);
		end
		if (k == 0) begin : g_head
			assign load_item = evt.single ? single_item : burst_item;
			assign load      = s_fire && emit;
		end else begin : g_body
			assign load_item = burst_item;
			assign load      = s_fire && evt.burst;
		end
		if (k == CHANNELS - 1) begin : g_tail
			assign next_item = '0;
		end else begin : g_mid
			assign next_item = out_item[k+1];
		end
		adf_out_cell u_cell (
			.clk       (clk),
			.load      (load),
			.load_item (load_item),
			.shift     (pop),
			.next_item (next_item),
			.item      (out_item[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (s_fire && evt.burst) begin
			cnt_q <= CNT_W'(CHANNELS);
		end else if (s_fire && evt.single) begin
			cnt_q <= CNT_W'(1);
		end else if (pop) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign m_tdata = {1'b0, out_item[0].skipped, out_item[0].frame,
	                  out_item[0].value, out_item[0].channel};
	assign m_tuser = {out_item[0].first, out_item[0].code};
	assign m_tlast = out_item[0].last;

`ifndef NO_ASSERTIONS
	a_load_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && emit) |-> (cnt_q == '0))
		else $error("result load into a busy chain");
	a_burst_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		(s_fire && evt.burst) |=> (cnt_q == CNT_W'(CHANNELS)))
		else $error("burst load count wrong");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CHANNELS))
		else $error("chain count overflow");
	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (cnt_q == CNT_W'(1))))
		else $error("last flag out of place");
`endif

endmodule

// File: bench/adc_frame_deframer_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_frame_deframer_core_tb: self-checking bench for the link deframer
// Streams link bytes through the block: short hand-picked sequences, then
// frames with random samples and counters, some with header, high-byte,
// closing, overflow or truncation flaws, mixed with noise bytes. An in-bench
// frame parser predicts every output word. Both sides idle at random, and
// the closing marker is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module adc_frame_deframer_core_tb;
	import adf_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE      = 40;

	localparam int FL_CLEAN  = 0;
	localparam int FL_HEADER = 1;
	localparam int FL_HIGH   = 2;
	localparam int FL_CLOSE  = 3;
	localparam int FL_FULL   = 4;
	localparam int FL_TRUNC  = 5;

	class deframe_tracker;
		typedef enum logic [2:0] {PH_SEARCH, PH_HEAD, PH_HIGH, PH_LOW, PH_CLOSE} phase_t;

		logic [7:0] close_marker;
		phase_t     phase;
		frame_t     cur_frame;
		frame_t     prev_frame;
		logic       prev_ok;
		logic [4:0] idx;
		logic       first_pend;
		logic       frame_first;
		sample_t    samples [CHANNELS];
		res_t       out_words [$];
		int         errors;

		function new();
			close_marker = CLOSE_RESET;
			phase        = PH_SEARCH;
			cur_frame    = '0;
			prev_frame   = '0;
			prev_ok      = 1'b0;
			idx          = '0;
			first_pend   = 1'b1;
			frame_first  = 1'b0;
			errors       = 0;
			foreach (samples[i]) samples[i] = '0;
		endfunction

		function void add_word(code_t c, channel_t ch, sample_t v, frame_t sk, logic f);
			res_t w;
			w.code    = c;
			w.channel = ch;
			w.value   = v;
			w.frame   = cur_frame;
			w.skipped = sk;
			w.first   = f;
			w.last    = 1'b0;
			out_words.push_back(w);
		endfunction

		function void restart();
			phase      = PH_SEARCH;
			prev_ok    = 1'b0;
			first_pend = 1'b1;
		endfunction

		function void take_link_byte(logic [7:0] b, logic full);
			int     n;
			int     pass;
			bit     again;
			frame_t gap;
			res_t   w;
			n = out_words.size();
			for (pass = 0; pass < 2; pass++) begin
				again = 1'b0;
				case (phase)
					PH_HEAD: begin
						if ((b & HDR2_MASK) == HDR_VALUE) begin
							gap = prev_ok ? frame_t'(cur_frame - prev_frame) : frame_t'(1);
							if (gap >= 6'd2) begin
								add_word(ERR_SKIP, '0, '0, frame_t'(gap - 6'd1), 1'b0);
								restart();
								again = 1'b1;
							end else begin
								frame_first = first_pend;
								first_pend  = 1'b0;
								idx         = '0;
								phase       = PH_HIGH;
							end
						end else if (!prev_ok) begin
							phase = PH_SEARCH;
							again = 1'b1;
						end else begin
							add_word(ERR_HEADER, '0, '0, '0, 1'b0);
							restart();
							again = 1'b1;
						end
					end
					PH_HIGH: begin
						if (b[7]) begin
							add_word(ERR_HIGH, '0, '0, '0, 1'b0);
							restart();
							again = 1'b1;
						end else begin
							samples[idx[3:0]] = {b[6:0], 8'h00};
							phase = PH_LOW;
						end
					end
					PH_LOW: begin
						samples[idx[3:0]] = samples[idx[3:0]] | {7'd0, b};
						idx = idx + 5'd1;
						if (idx >= 5'(CHANNELS)) begin
							prev_frame = cur_frame;
							prev_ok    = 1'b1;
							phase      = PH_CLOSE;
						end else begin
							phase = PH_HIGH;
						end
					end
					PH_CLOSE: begin
						if (b != close_marker) begin
							add_word(ERR_CLOSE, '0, '0, '0, 1'b0);
							restart();
							again = 1'b1;
						end else begin
							phase = PH_SEARCH;
							if (full) begin
								add_word(ERR_OVERFLOW, '0, '0, '0, 1'b0);
								first_pend = 1'b1;
							end else begin
								for (int k = 0; k < CHANNELS; k++)
									add_word(ERR_SAMPLE, channel_t'(k),
										samples[SIDX_W'((k + 1) % CHANNELS)], '0,
										frame_first);
							end
						end
					end
					default: begin
						phase = PH_SEARCH;
						if ((b & HDR1_MASK) == HDR_VALUE) begin
							phase     = PH_HEAD;
							cur_frame = b[5:0];
						end
					end
				endcase
				if (!again)
					break;
			end
			if (out_words.size() > n) begin
				w = out_words[out_words.size() - 1];
				w.last = 1'b1;
				out_words[out_words.size() - 1] = w;
			end
		endfunction

		task report_mismatch(string what, int want, int got);
			$display("mismatch %s: expected %0h got %0h at %0t", what, want, got, $realtime);
			errors++;
		endtask

		task check_out_word(res_t got);
			res_t want;
			if (out_words.size() == 0) begin
				report_mismatch("unexpected word", 0, int'(got.code));
				return;
			end
			want = out_words.pop_front();
			if (got.code !== want.code)
				report_mismatch("error_code", int'(want.code), int'(got.code));
			if (got.channel !== want.channel)
				report_mismatch("channel", int'(want.channel), int'(got.channel));
			if (got.value !== want.value)
				report_mismatch("sample_value", int'(want.value), int'(got.value));
			if (got.frame !== want.frame)
				report_mismatch("frame_number", int'(want.frame), int'(got.frame));
			if (got.skipped !== want.skipped)
				report_mismatch("skipped_count", int'(want.skipped), int'(got.skipped));
			if (got.first !== want.first)
				report_mismatch("first_of_stream", int'(want.first), int'(got.first));
			if (got.last !== want.last)
				report_mismatch("last", int'(want.last), int'(got.last));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;

	deframe_tracker sb;
	int             cycles;
	int             rx_cycle;
	int             rx_mode;
	int             burst_left;
	int             bytes_sent;
	frame_t         last_cnt;

	adc_frame_deframer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL adc_frame_deframer_core");
			$finish;
		end
	end

	// accepted input first, then the output word of the same edge
	always @(posedge clk) begin
		res_t got;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_link_byte(s_tdata, s_tuser[0]);
			if (m_tvalid && m_tready) begin
				got.code    = m_tuser[2:0];
				got.first   = m_tuser[3];
				got.channel = m_tdata[3:0];
				got.value   = m_tdata[18:4];
				got.frame   = m_tdata[24:19];
				got.skipped = m_tdata[30:25];
				got.last    = m_tlast;
				sb.check_out_word(got);
			end
		end
	end

	always @(negedge clk) begin
		rx_cycle++;
		if (rx_cycle % 48 == 0)
			rx_mode = $urandom_range(0, 3);
		case (rx_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 1) == 1);
			2:       m_tready <= ($urandom_range(0, 5) == 0);
			default: m_tready <= (rx_cycle % 5 != 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic full);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_tvalid   <= 1'b1;
		s_tdata    <= b;
		s_tuser[0] <= full;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		bytes_sent++;
		@(negedge clk);
	endtask

	function automatic logic [7:0] pick_value(input logic [7:0] top);
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return top;
			default: return 8'($urandom_range(0, top));
		endcase
	endfunction

	task automatic send_frame(input frame_t cnt, input int flaw);
		int         cut;
		logic [7:0] b;
		cut = $urandom_range(0, CHANNELS - 1);
		send_byte({2'b10, cnt}, 1'($urandom_range(0, 1)));
		if (flaw == FL_HEADER) begin
			do b = 8'($urandom); while ((b & HDR2_MASK) == HDR_VALUE);
			send_byte(b, 1'($urandom_range(0, 1)));
			return;
		end
		send_byte({2'b10, 2'($urandom), 4'h0}, 1'($urandom_range(0, 1)));
		for (int k = 0; k < CHANNELS; k++) begin
			if (k == cut && flaw == FL_HIGH) begin
				send_byte(8'($urandom_range(128, 255)), 1'($urandom_range(0, 1)));
				return;
			end
			if (k == cut && flaw == FL_TRUNC && $urandom_range(0, 1) == 0)
				return;
			send_byte(pick_value(8'h7F), 1'($urandom_range(0, 1)));
			if (k == cut && flaw == FL_TRUNC)
				return;
			send_byte(pick_value(8'hFF), 1'($urandom_range(0, 1)));
		end
		if (flaw == FL_CLOSE) begin
			do b = 8'($urandom); while (b == sb.close_marker);
			send_byte(b, 1'($urandom_range(0, 1)));
		end else begin
			send_byte(sb.close_marker, flaw == FL_FULL);
		end
	endtask

	task automatic run_random(input int quota);
		int     target;
		int     f;
		int     c;
		frame_t cnt;
		target = bytes_sent + quota;
		while (bytes_sent < target) begin
			if ($urandom_range(0, 9) < 7) begin
				c = $urandom_range(0, 9);
				if (c == 0)
					cnt = last_cnt;
				else if (c == 1)
					cnt = frame_t'(last_cnt + $urandom_range(2, 63));
				else
					cnt = frame_t'(last_cnt + 1);
				f = $urandom_range(0, 11);
				send_frame(cnt, (f <= FL_TRUNC) ? f : FL_CLEAN);
				last_cnt = cnt;
			end else begin
				repeat ($urandom_range(1, 3))
					send_byte(8'($urandom), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (sb.out_words.size() != 0);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_marker(input logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		sb.close_marker = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		sb         = new();
		cycles     = 0;
		rx_cycle   = 0;
		rx_mode    = 0;
		burst_left = 0;
		bytes_sent = 0;
		last_cnt   = frame_t'($urandom);
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = '0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		s_tuser    = '0;
		m_tready   = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		// bad second header with no previous frame: silent, reparse
		send_byte(8'hBF, 1'b0);
		send_byte(8'hFF, 1'b0);
		// bad high byte right after a good header pair
		send_byte(8'h80, 1'b0);
		send_byte(8'hB0, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hC5, 1'b1);
		// second header byte that is itself a header: reparse as a new frame
		send_byte(8'h81, 1'b0);
		send_byte(8'h8F, 1'b0);
		send_byte(8'hB0, 1'b0);
		send_byte(8'h7F, 1'b1);
		send_byte(8'hFF, 1'b0);
		run_random(90);

		drain();
		write_marker(8'h00);
		run_random(90);

		drain();
		write_marker(8'hFF);
		run_random(90);

		drain();
		write_marker(8'($urandom));
		run_random(90);

		drain();
		if (sb.errors == 0)
			$display("PASS adc_frame_deframer_core");
		else
			$display("FAIL adc_frame_deframer_core");
		$finish;
	end

endmodule
